[hw/rtl/cst_pkg.sv]
`default_nettype none

package cst_pkg;

   localparam int COST_W  = 16;
   localparam int VALUE_W = 16;
   localparam int POS_W   = 5;
   localparam int ENTRY_W = 5;

   // Request kinds.
   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_SORT   = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;
   localparam logic [1:0] REQ_PEEK   = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [COST_W-1:0]  cost;
      logic [VALUE_W-1:0] value;
   } record_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SHIFT,
      ST_SCAN_START,
      ST_SCAN,
      ST_PLACE,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/cst_req_if.sv]
`default_nettype none

interface cst_req_if;
   import cst_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [COST_W-1:0]  item_cost;
   logic [VALUE_W-1:0] item_value;
   logic [POS_W-1:0]   position;

   modport source (
      output valid, req_type, item_cost, item_value, position,
      input  ready
   );

   modport sink (
      input  valid, req_type, item_cost, item_value, position,
      output ready
   );
endinterface

`default_nettype wire

[hw/rtl/cst_rsp_if.sv]
`default_nettype none

interface cst_rsp_if;
   import cst_pkg::*;

   logic               valid;
   logic               ready;
   logic [COST_W-1:0]  out_cost;
   logic [VALUE_W-1:0] out_value;
   logic [1:0]         status;
   logic [ENTRY_W-1:0] entry_count;

   modport source (
      output valid, out_cost, out_value, status, entry_count,
      input  ready
   );

   modport sink (
      input  valid, out_cost, out_value, status, entry_count,
      output ready
   );
endinterface

`default_nettype wire

[hw/rtl/cost_sorted_item_table_top.sv]
`default_nettype none

// Channel   Dir  Payload                                     Handshake
// req_ch    in   req_type, item_cost, item_value, position   valid/ready
// rsp_ch    out  out_cost, out_value, status, entry_count    valid/ready
//
// One item at a time. A remove moves every record above the removed one down a
// slot, and a sort inserts each record in turn, shifting each record that costs
// more up past it; the record RAM has a single read and a single write port.
// Reset is synchronous and empties the table. The result sits in an output
// register, so a new item is taken while it waits.
module cost_sorted_item_table_top #(
   parameter int MAX_RECORDS = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   cst_req_if.sink   req_ch,
   cst_rsp_if.source rsp_ch
);
   import cst_pkg::*;

   localparam int AW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CW  = $clog2(MAX_RECORDS + 1);
   localparam int PCW = (CW > POS_W) ? CW : POS_W;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     i_ff, i_in;
   logic [AW-1:0]     j_ff, j_in;
   logic [1:0]        op_ff, op_in;
   record_type        key_ff, key_in;
   record_type        pend_rec_ff, pend_rec_in;
   logic [1:0]        pend_status_ff, pend_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   record_type        rsp_rec_ff;
   logic [1:0]        rsp_status_ff;
   logic [ENTRY_W-1:0] rsp_count_ff;

   logic              rsp_load;
   logic              accept;
   logic              in_range;
   logic [PCW-1:0]    pos_ext;
   logic [AW-1:0]     pos_idx;

   logic              rd_en, wr_en;
   logic [AW-1:0]     rd_addr, wr_addr;
   record_type        rd_data, wr_data;

   cst_rec_ram #(
      .DEPTH (MAX_RECORDS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_ch.ready = (state_ff == ST_IDLE) && !reset;
   assign accept       = req_ch.valid && req_ch.ready;
   assign pos_ext      = PCW'(req_ch.position);
   assign in_range     = (req_ch.position != '0) && (pos_ext <= PCW'(count_ff));
   assign pos_idx      = AW'(pos_ext - PCW'(1));

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      pend_rec_in    = pend_rec_ff;
      pend_status_in = pend_status_ff;
      rd_en          = 1'b0;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = '0;
      rsp_load       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in          = req_ch.req_type;
               pend_rec_in    = '0;
               pend_status_in = STATUS_OK;
               state_in       = ST_RESP;
               case (req_ch.req_type)
                  REQ_APPEND: begin
                     if (count_ff == CW'(MAX_RECORDS)) begin
                        pend_status_in = STATUS_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = AW'(count_ff);
                        wr_data.cost  = req_ch.item_cost;
                        wr_data.value = req_ch.item_value;
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  REQ_SORT: begin
                     if (count_ff >= CW'(2)) begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(1);
                        i_in     = AW'(1);
                        state_in = ST_SCAN_START;
                     end
                  end
                  default: begin
                     if (in_range) begin
                        rd_en    = 1'b1;
                        rd_addr  = pos_idx;
                        j_in     = pos_idx;
                        state_in = ST_FETCH;
                     end else begin
                        pend_status_in = STATUS_RANGE;
                     end
                  end
               endcase
            end
         end

         ST_FETCH: begin
            pend_rec_in = rd_data;
            state_in    = ST_RESP;
            if (op_ff == REQ_REMOVE) begin
               if (CW'(j_ff) + CW'(1) < count_ff) begin
                  rd_en    = 1'b1;
                  rd_addr  = j_ff + AW'(1);
                  state_in = ST_SHIFT;
               end else begin
                  count_in = count_ff - CW'(1);
               end
            end
         end

         // Close the gap: read one slot ahead while writing the record below it.
         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = rd_data;
            j_in    = j_ff + AW'(1);
            if (CW'(j_ff) + CW'(2) < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = j_ff + AW'(2);
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ST_RESP;
            end
         end

         ST_SCAN_START: begin
            key_in  = rd_data;
            j_in    = i_ff;
            rd_en   = 1'b1;
            rd_addr = i_ff - AW'(1);
            state_in = ST_SCAN;
         end

         // The record below the hole arrives; move it up if it costs strictly
         // more than the key, which keeps equal costs in their original order.
         ST_SCAN: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            if (rd_data.cost > key_ff.cost) begin
               wr_data = rd_data;
               j_in    = j_ff - AW'(1);
               if (j_ff == AW'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = j_ff - AW'(2);
               end
            end else begin
               wr_data = key_ff;
               if (CW'(i_ff) + CW'(1) < count_ff) begin
                  rd_en    = 1'b1;
                  rd_addr  = i_ff + AW'(1);
                  i_in     = i_ff + AW'(1);
                  state_in = ST_SCAN_START;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end

         ST_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = key_ff;
            if (CW'(i_ff) + CW'(1) < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = i_ff + AW'(1);
               i_in     = i_ff + AW'(1);
               state_in = ST_SCAN_START;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff           <= i_in;
      j_ff           <= j_in;
      op_ff          <= op_in;
      key_ff         <= key_in;
      pend_rec_ff    <= pend_rec_in;
      pend_status_ff <= pend_status_in;
      if (rsp_load) begin
         rsp_rec_ff    <= pend_rec_ff;
         rsp_status_ff <= pend_status_ff;
         rsp_count_ff  <= ENTRY_W'(count_ff);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_cost    = rsp_rec_ff.cost;
   assign rsp_ch.out_value   = rsp_rec_ff.value;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_count = rsp_count_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_RECORDS))
      else $error("record count exceeds table depth");

   a_write_in_table : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) <= count_ff))
      else $error("write beyond the held records");

   a_scan_hole : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (j_ff != '0 && j_ff <= i_ff))
      else $error("insertion hole outside the sorted prefix");

   a_result_from_resp : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result loaded outside the response state");

endmodule

`default_nettype wire

[hw/rtl/cst_rec_ram.sv]
`default_nettype none

module cst_rec_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic                clock,
   input  wire logic                rd_en,
   input  wire logic [AW-1:0]       rd_addr,
   output cst_pkg::record_type      rd_data,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire cst_pkg::record_type wr_data
);
   import cst_pkg::*;

   record_type mem [DEPTH];
   record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import cst_pkg::*;

   localparam int TABLE_DEPTH     = 16;
   localparam int DIRECTED_ROWS   = 25;
   localparam int PHASE_ITEMS     = 150;
   localparam int PRESSURE_ITEMS  = 100;
   localparam int PRESSURE_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [1:0]         kind;
      logic [COST_W-1:0]  cost;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
   } table_req_type;

   typedef struct packed {
      logic [COST_W-1:0]  cost;
      logic [VALUE_W-1:0] value;
      logic [1:0]         status;
      logic [ENTRY_W-1:0] entries;
   } table_rsp_type;

   // A row with reps above one is issued that many times, the cost stepping
   // down and the value stepping up on each repeat.
   typedef struct packed {
      table_req_type req;
      int            reps;
      bit            typed;
      table_rsp_type rsp;
   } directed_row_type;

   logic clock;
   logic reset;
   logic hold_rsp;
   logic pressure_go;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   err_count;

   // Predicted contents of the table.
   logic [COST_W-1:0]  table_cost  [TABLE_DEPTH];
   logic [VALUE_W-1:0] table_value [TABLE_DEPTH];
   int                 table_count;

   table_rsp_type expected_rsps [$];

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{REQ_PEEK,   16'h0000, 16'h0000, 5'd0},  1, 1'b1, '{16'h0, 16'h0, STATUS_RANGE, 5'd0}},
      '{'{REQ_REMOVE, 16'h0000, 16'h0000, 5'd1},  1, 1'b1, '{16'h0, 16'h0, STATUS_RANGE, 5'd0}},
      '{'{REQ_SORT,   16'h0000, 16'h0000, 5'd0},  1, 1'b1, '{16'h0, 16'h0, STATUS_OK, 5'd0}},
      '{'{REQ_APPEND, 16'hFFFF, 16'h0000, 5'd0},  1, 1'b1, '{16'h0, 16'h0, STATUS_OK, 5'd1}},
      '{'{REQ_SORT,   16'h0000, 16'h0000, 5'd0},  1, 1'b1, '{16'h0, 16'h0, STATUS_OK, 5'd1}},
      '{'{REQ_PEEK,   16'h0000, 16'h0000, 5'd1},  1, 1'b1,
        '{16'hFFFF, 16'h0000, STATUS_OK, 5'd1}},
      '{'{REQ_APPEND, 16'h0000, 16'hFFFF, 5'd0},  1, 1'b1, '{16'h0, 16'h0, STATUS_OK, 5'd2}},
      '{'{REQ_APPEND, 16'h0005, 16'h0001, 5'd0},  1, 1'b1, '{16'h0, 16'h0, STATUS_OK, 5'd3}},
      '{'{REQ_APPEND, 16'h0005, 16'h0002, 5'd0},  1, 1'b1, '{16'h0, 16'h0, STATUS_OK, 5'd4}},
      '{'{REQ_APPEND, 16'h0000, 16'h0003, 5'd0},  1, 1'b1, '{16'h0, 16'h0, STATUS_OK, 5'd5}},
      '{'{REQ_SORT,   16'h0000, 16'h0000, 5'd0},  1, 1'b1, '{16'h0, 16'h0, STATUS_OK, 5'd5}},
      '{'{REQ_PEEK,   16'h0000, 16'h0000, 5'd1},  1, 1'b0, '0},
      '{'{REQ_PEEK,   16'h0000, 16'h0000, 5'd2},  1, 1'b0, '0},
      '{'{REQ_PEEK,   16'h0000, 16'h0000, 5'd3},  1, 1'b0, '0},
      '{'{REQ_PEEK,   16'h0000, 16'h0000, 5'd4},  1, 1'b0, '0},
      '{'{REQ_REMOVE, 16'h0000, 16'h0000, 5'd5},  1, 1'b0, '0},
      '{'{REQ_REMOVE, 16'h0000, 16'h0000, 5'd1},  1, 1'b0, '0},
      '{'{REQ_PEEK,   16'h0000, 16'h0000, 5'd4},  1, 1'b1, '{16'h0, 16'h0, STATUS_RANGE, 5'd3}},
      '{'{REQ_PEEK,   16'h0000, 16'h0000, 5'd31}, 1, 1'b1, '{16'h0, 16'h0, STATUS_RANGE, 5'd3}},
      '{'{REQ_APPEND, 16'h8000, 16'h0100, 5'd0}, 13, 1'b0, '0},
      '{'{REQ_APPEND, 16'hFFFF, 16'hFFFF, 5'd0},  1, 1'b1, '{16'h0, 16'h0, STATUS_FULL, 5'd16}},
      '{'{REQ_SORT,   16'h0000, 16'h0000, 5'd0},  1, 1'b0, '0},
      '{'{REQ_PEEK,   16'h0000, 16'h0000, 5'd16}, 1, 1'b0, '0},
      '{'{REQ_REMOVE, 16'h0000, 16'h0000, 5'd17}, 1, 1'b1,
        '{16'h0, 16'h0, STATUS_RANGE, 5'd16}},
      '{'{REQ_REMOVE, 16'h0000, 16'h0000, 5'd16}, 1, 1'b0, '0}
   };

   cst_req_if req_ch ();
   cst_rsp_if rsp_ch ();

   cost_sorted_item_table_top #(
      .MAX_RECORDS(TABLE_DEPTH)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   // Applies one request to the predicted table and returns its result.
   function automatic table_rsp_type apply_request(input table_req_type r);
      table_rsp_type      res;
      logic [COST_W-1:0]  key_cost;
      logic [VALUE_W-1:0] key_value;
      int                 i;
      int                 j;
      int                 idx;
      res = '0;
      res.status = STATUS_OK;
      case (r.kind)
         REQ_APPEND: begin
            if (table_count >= TABLE_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               table_cost[table_count]  = r.cost;
               table_value[table_count] = r.value;
               table_count++;
            end
         end
         REQ_SORT: begin
            for (i = 1; i < table_count; i++) begin
               key_cost  = table_cost[i];
               key_value = table_value[i];
               j = i;
               // Strict compare keeps records of equal cost in arrival order.
               while (j > 0 && table_cost[j-1] > key_cost) begin
                  table_cost[j]  = table_cost[j-1];
                  table_value[j] = table_value[j-1];
                  j--;
               end
               table_cost[j]  = key_cost;
               table_value[j] = key_value;
            end
         end
         default: begin
            if (r.position == 0 || int'(r.position) > table_count) begin
               res.status = STATUS_RANGE;
            end else begin
               idx = int'(r.position) - 1;
               res.cost  = table_cost[idx];
               res.value = table_value[idx];
               if (r.kind == REQ_REMOVE) begin
                  for (i = idx; i + 1 < table_count; i++) begin
                     table_cost[i]  = table_cost[i+1];
                     table_value[i] = table_value[i+1];
                  end
                  table_count--;
               end
            end
         end
      endcase
      res.entries = ENTRY_W'(table_count);
      return res;
   endfunction

   // Random request; the append share swings up and down in blocks of items
   // so the table keeps filling to the top and draining to empty.
   function automatic table_req_type random_req(input int n);
      table_req_type r;
      int            fill_bias;
      int            pick;
      int            hi;
      fill_bias = ((n / 40) % 2 == 0) ? 55 : 25;
      pick = $urandom_range(99);
      if (pick < fill_bias) begin
         r.kind = REQ_APPEND;
      end else if (pick < fill_bias + 10) begin
         r.kind = REQ_SORT;
      end else if (pick < fill_bias + 10 + (90 - fill_bias) / 2) begin
         r.kind = REQ_REMOVE;
      end else begin
         r.kind = REQ_PEEK;
      end
      case ($urandom_range(3))
         0:       r.cost = COST_W'($urandom_range(7));
         1:       r.cost = $urandom_range(1) ? 16'hFFFF : 16'h0000;
         default: r.cost = COST_W'($urandom);
      endcase
      r.value = VALUE_W'($urandom);
      hi = (table_count < 1) ? 1 : table_count;
      if ($urandom_range(9) < 8) begin
         r.position = POS_W'($urandom_range(1, hi));
      end else begin
         r.position = POS_W'($urandom_range(31));
      end
      return r;
   endfunction

   // Offers one item; on return it has been taken at the current edge.
   task automatic push_req(input table_req_type r, input bit typed,
                           input table_rsp_type typed_rsp);
      table_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= r.kind;
      req_ch.item_cost  <= r.cost;
      req_ch.item_value <= r.value;
      req_ch.position   <= r.position;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = apply_request(r);
      expected_rsps.push_back(typed ? typed_rsp : predicted);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : stimulus
      table_req_type r;
      int            i;
      int            k;
      int            n;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_APPEND;
      req_ch.item_cost  <= '0;
      req_ch.item_value <= '0;
      req_ch.position   <= '0;
      pressure_go       <= 1'b0;
      recv_stall_pct    <= 0;
      send_idle_pct = 0;
      err_count     = 0;
      table_count   = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         for (k = 0; k < directed_rows[i].reps; k++) begin
            r = directed_rows[i].req;
            r.cost  = r.cost - COST_W'(k);
            r.value = r.value + VALUE_W'(k);
            push_req(r, directed_rows[i].typed, directed_rows[i].rsp);
         end
      end

      n = 0;
      for (i = 0; i < 4; i++) begin
         case (i)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 50; end
            default: begin send_idle_pct = 36; recv_stall_pct <= 36; end
         endcase
         for (k = 0; k < PHASE_ITEMS; k++) begin
            push_req(random_req(n), 1'b0, '0);
            n++;
         end
      end

      // The receiver goes quiet for a long stretch while items keep coming.
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      pressure_go    <= 1'b1;
      for (k = 0; k < PRESSURE_ITEMS; k++) begin
         push_req(random_req(n), 1'b0, '0);
         n++;
      end
      req_ch.valid <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : pressure
      hold_rsp <= 1'b0;
      @(posedge clock);
      while (!pressure_go) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (PRESSURE_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin : rsp_checker
      table_rsp_type got;
      table_rsp_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.cost    = rsp_ch.out_cost;
            got.value   = rsp_ch.out_value;
            got.status  = rsp_ch.status;
            got.entries = rsp_ch.entry_count;
            if (expected_rsps.size() == 0) begin
               if (err_count < REPORT_LIMIT) begin
                  $display("unexpected result: cost %h value %h status %0d entries %0d",
                           got.cost, got.value, got.status, got.entries);
               end
               err_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.cost !== want.cost || got.value !== want.value ||
                   got.status !== want.status || got.entries !== want.entries) begin
                  if (err_count < REPORT_LIMIT) begin
                     $display("mismatch: expected cost %h value %h status %0d entries %0d",
                              want.cost, want.value, want.status, want.entries);
                     $display("          actual   cost %h value %h status %0d entries %0d",
                              got.cost, got.value, got.status, got.entries);
                  end
                  err_count++;
               end
            end
         end
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/cst_pkg.sv
hw/rtl/cst_req_if.sv
hw/rtl/cst_rsp_if.sv
hw/rtl/cst_rec_ram.sv
hw/rtl/cost_sorted_item_table_top.sv
tb/sv/tb.sv
